[rtl/ftd_pkg.sv]
// Shared constants, command encoding and arithmetic helpers of the fixed-time differentiator.
package ftd_pkg;

    // Saturation limits of the 32-bit signed Q16.16 datapath.
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // Iteration counts.
    localparam int NORM_STEPS  = 5;
    localparam int FRAC_STEPS  = 24;
    localparam int ROOT_CYCLES = 16;
    localparam int POWERS      = 6;
    localparam int POST_OPS    = 6;
    localparam int EST_COUNT   = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FIRST     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SECOND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_THIRD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_EXPONENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_EXPONENT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_ESTIMATE = 3'd6;

    // Register reset values.
    localparam logic [31:0] GAIN_RESET     = 32'd32768;
    localparam logic [15:0] SLOW_EXP_RESET = 16'd8192;
    localparam logic [15:0] FAST_EXP_RESET = 16'd24576;
    localparam logic [23:0] STEP_RESET     = 24'd838861;

    // Exponent arithmetic in Q2.14: 1.0, 2.0 and the reciprocal of 3 scaled by 2^17.
    localparam logic [16:0] EXP_ONE    = 17'd16384;
    localparam logic [16:0] EXP_TWO    = 17'd32768;
    localparam logic [16:0] DIV3_RECIP = 17'd43691;

    // 1.0 in the Q1.30 format of the exponential root chain.
    localparam logic [30:0] ROOT_ONE = 31'h4000_0000;

    // Datapath operation codes.
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_CAPTURE = 4'd1;
    localparam logic [3:0] OP_NORM    = 4'd2;
    localparam logic [3:0] OP_SQUARE  = 4'd3;
    localparam logic [3:0] OP_PLOAD   = 4'd4;
    localparam logic [3:0] OP_EXPMUL  = 4'd5;
    localparam logic [3:0] OP_SLOAD   = 4'd6;
    localparam logic [3:0] OP_SITER   = 4'd7;
    localparam logic [3:0] OP_FIN     = 4'd8;
    localparam logic [3:0] OP_SUM     = 4'd9;
    localparam logic [3:0] OP_GMUL    = 4'd10;
    localparam logic [3:0] OP_GSHIFT  = 4'd11;
    localparam logic [3:0] OP_SLOPE   = 4'd12;
    localparam logic [3:0] OP_IMUL    = 4'd13;
    localparam logic [3:0] OP_INTEG   = 4'd14;
    localparam logic [3:0] OP_OUTLOAD = 4'd15;

    // Command from the controller: operation and a step, power or estimate index.
    typedef struct packed {
        logic [3:0] op;
        logic [4:0] idx;
    } t_cmd;

    // State of the bit-pair integer square root.
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] one_hot;
    } t_root;

    // Saturate a 34-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] o;
        if (v > 34'sd2147483647) begin
            o = SAT_MAX;
        end else if (v < -34'sd2147483648) begin
            o = SAT_MIN;
        end else begin
            o = v[31:0];
        end
        return o;
    endfunction

    // Apply a sign to a 48-bit magnitude and saturate to 32 bits.
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [47:0] m);
        logic signed [31:0] o;
        if (!neg) begin
            o = (m > 48'd2147483647) ? SAT_MAX : $signed(m[31:0]);
        end else begin
            o = (m > 48'd2147483648) ? SAT_MIN : $signed(32'(-m[31:0]));
        end
        return o;
    endfunction

    // One restoring step of the integer square root.
    function automatic t_root root_step(input t_root s);
        t_root       o;
        logic [63:0] trial;
        trial = s.res + s.one_hot;
        o     = s;
        if (s.rem >= trial) begin
            o.rem = s.rem - trial;
            o.res = (s.res >> 1) + s.one_hot;
        end else begin
            o.res = s.res >> 1;
        end
        o.one_hot = s.one_hot >> 2;
        return o;
    endfunction

endpackage

[rtl/ftd_if.sv]
// Channel interfaces of the fixed-time differentiator: samples, results and configuration.
interface ftd_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] error_sample;

    modport source (output valid, output error_sample, input ready);
    modport sink (input valid, input error_sample, output ready);
endinterface

interface ftd_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] estimate_value;
    logic signed [31:0] estimate_rate;
    logic signed [31:0] estimate_accel;

    modport source (output valid, output estimate_value, output estimate_rate,
                    output estimate_accel, input ready);
    modport sink (input valid, input estimate_value, input estimate_rate,
                  input estimate_accel, output ready);
endinterface

interface ftd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ftd_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/ftd_ctrl.sv]
// Sequencer of the differentiator: walks log, six powers and the integration steps.
module ftd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ftd_pkg::t_cmd o_cmd
);
    import ftd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NORM  = 4'd1;
    localparam logic [3:0] S_SQ    = 4'd2;
    localparam logic [3:0] S_PLOAD = 4'd3;
    localparam logic [3:0] S_EMUL  = 4'd4;
    localparam logic [3:0] S_SLOAD = 4'd5;
    localparam logic [3:0] S_SITER = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_POST  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [3:0] r_it, n_it;
    logic [2:0] r_pow, n_pow;
    logic [1:0] r_est, n_est;
    logic [2:0] r_pstep, n_pstep;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic [3:0] post_op;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Operation of each step of the integration sequence.
    always_comb begin
        unique case (r_pstep)
            3'd0:    post_op = OP_SUM;
            3'd1:    post_op = OP_GMUL;
            3'd2:    post_op = OP_GSHIFT;
            3'd3:    post_op = OP_SLOPE;
            3'd4:    post_op = OP_IMUL;
            3'd5:    post_op = OP_INTEG;
            default: post_op = OP_NONE;
        endcase
    end

    // Next state and command.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_it        = r_it;
        n_pow       = r_pow;
        n_est       = r_est;
        n_pstep     = r_pstep;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '{op: OP_NONE, idx: 5'd0};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_cnt    = 5'd0;
                    n_state  = S_NORM;
                end
            end
            S_NORM: begin
                o_cmd = '{op: OP_NORM, idx: r_cnt};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(NORM_STEPS - 1)) begin
                    n_cnt   = 5'd0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.op = OP_SQUARE;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'(FRAC_STEPS - 1)) begin
                    n_pow   = 3'd0;
                    n_state = S_PLOAD;
                end
            end
            S_PLOAD: begin
                o_cmd   = '{op: OP_PLOAD, idx: {2'b00, r_pow}};
                n_state = S_EMUL;
            end
            S_EMUL: begin
                o_cmd.op = OP_EXPMUL;
                n_cnt    = 5'd0;
                n_state  = S_SLOAD;
            end
            S_SLOAD: begin
                o_cmd   = '{op: OP_SLOAD, idx: r_cnt};
                n_it    = 4'd0;
                n_state = S_SITER;
            end
            S_SITER: begin
                o_cmd.op = OP_SITER;
                n_it     = r_it + 4'd1;
                if (r_it == 4'(ROOT_CYCLES - 1)) begin
                    if (r_cnt == 5'(FRAC_STEPS - 1)) begin
                        n_state = S_FIN;
                    end else begin
                        n_cnt   = r_cnt + 5'd1;
                        n_state = S_SLOAD;
                    end
                end
            end
            S_FIN: begin
                o_cmd = '{op: OP_FIN, idx: {2'b00, r_pow}};
                if (r_pow == 3'(POWERS - 1)) begin
                    n_est   = 2'd0;
                    n_pstep = 3'd0;
                    n_state = S_POST;
                end else begin
                    n_pow   = r_pow + 3'd1;
                    n_state = S_PLOAD;
                end
            end
            S_POST: begin
                o_cmd   = '{op: post_op, idx: {3'b000, r_est}};
                n_pstep = r_pstep + 3'd1;
                if (r_pstep == 3'(POST_OPS - 1)) begin
                    n_pstep = 3'd0;
                    if (r_est == 2'(EST_COUNT - 1)) begin
                        n_state = S_OUT;
                    end else begin
                        n_est = r_est + 2'd1;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.op    = OP_OUTLOAD;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 5'd0;
            r_it        <= 4'd0;
            r_pow       <= 3'd0;
            r_est       <= 2'd0;
            r_pstep     <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_it        <= n_it;
            r_pow       <= n_pow;
            r_est       <= n_est;
            r_pstep     <= n_pstep;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/ftd_datapath.sv]
// Datapath of the differentiator: registers, log/exp power unit, square root and integrators.
module ftd_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ftd_pkg::t_cmd                 i_cmd,
    input  logic signed [31:0]            i_sample,
    input  logic                          i_cfg_we,
    input  logic [ftd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output logic signed [31:0]            o_estimate_value,
    output logic signed [31:0]            o_estimate_rate,
    output logic signed [31:0]            o_estimate_accel
);
    import ftd_pkg::*;

    // Configuration registers. The start estimate is only needed at the moment it is
    // written, when it goes straight into the value estimate.
    logic [31:0]        r_gain_first, r_gain_second, r_gain_third;
    logic [15:0]        r_slow_exp, r_fast_exp;
    logic [23:0]        r_step_time;

    // Filter state.
    logic signed [31:0] r_est_accel, r_est_rate, r_est_value;
    logic signed [31:0] r_prev_accel, r_prev_rate, r_prev_value;

    // Working registers.
    logic [31:0]        r_mag_z;
    logic [4:0]         r_lead;
    logic [23:0]        r_frac;
    logic               r_neg_in, r_zero_in;
    logic [15:0]        r_exp;
    logic signed [6:0]  r_pow_n;
    logic [23:0]        r_pow_f;
    logic [30:0]        r_root;
    t_root              r_rs;
    logic signed [31:0] r_sig [POWERS];
    logic signed [31:0] r_work;
    logic [63:0]        r_prod;
    logic               r_prod_neg;
    logic signed [31:0] r_term;
    logic signed [31:0] r_slope;
    logic signed [32:0] r_slope_sum;
    logic signed [31:0] r_out_value, r_out_rate, r_out_accel;

    logic [31:0]        sample_mag;
    logic [4:0]         norm_amt;
    logic [31:0]        norm_mask;
    logic [63:0]        sq_full;
    logic [32:0]        sq_top;
    logic [16:0]        slow_sum1, fast_sum1, slow_sum2, fast_sum2;
    logic [33:0]        slow_div, fast_div;
    logic [15:0]        exp_sel;
    logic signed [28:0] log_val;
    logic signed [45:0] y_full;
    logic [31:0]        root_in;
    t_root              rs1, rs2;
    logic signed [8:0]  shift_amt;
    logic [31:0]        fin_mag;
    logic signed [31:0] fin_sig;
    logic [1:0]         q;
    logic signed [31:0] sig_a, sig_b, upper, prev_sel, est_sel;
    logic [31:0]        gain_sel;
    logic signed [31:0] sum_sat;
    logic [31:0]        work_mag;
    logic signed [31:0] slope_val;
    logic [32:0]        ss_mag;
    logic [56:0]        iprod;
    logic [31:0]        inc_mag;
    logic signed [33:0] inc;
    logic signed [31:0] est_next;

    assign q = i_cmd.idx[1:0];

    // Magnitude of the captured sample.
    assign sample_mag = i_sample[31] ? 32'(-i_sample) : 32'(i_sample);

    // Normalizing shift, one halving of the shift amount per cycle.
    assign norm_amt  = 5'd16 >> i_cmd.idx[2:0];
    assign norm_mask = ~(32'hFFFF_FFFF >> norm_amt);

    // Repeated squaring for the fraction bits of log2.
    assign sq_full = 64'(r_mag_z) * 64'(r_mag_z);
    assign sq_top  = sq_full[63:31];

    // Derived exponents: (p + 1.0) / 2 and (p + 2.0) / 3 via a reciprocal.
    assign slow_sum1 = 17'(r_slow_exp) + EXP_ONE;
    assign fast_sum1 = 17'(r_fast_exp) + EXP_ONE;
    assign slow_sum2 = 17'(r_slow_exp) + EXP_TWO;
    assign fast_sum2 = 17'(r_fast_exp) + EXP_TWO;
    assign slow_div  = 34'(slow_sum2) * 34'(DIV3_RECIP);
    assign fast_div  = 34'(fast_sum2) * 34'(DIV3_RECIP);

    always_comb begin
        unique case (i_cmd.idx[2:0])
            3'd0:    exp_sel = r_slow_exp;
            3'd1:    exp_sel = r_fast_exp;
            3'd2:    exp_sel = slow_sum1[16:1];
            3'd3:    exp_sel = fast_sum1[16:1];
            3'd4:    exp_sel = slow_div[32:17];
            3'd5:    exp_sel = fast_div[32:17];
            default: exp_sel = r_slow_exp;
        endcase
    end

    // log2 in Q.24: integer part is the leading-one position minus 16.
    assign log_val = $signed({~r_lead[4], r_lead[3:0], r_frac});
    assign y_full  = 46'(log_val) * 46'($signed({1'b0, r_exp}));

    // Square-root chain for 2^f: double on a set fraction bit, then root.
    assign root_in = r_pow_f[i_cmd.idx] ? {r_root, 1'b0} : {1'b0, r_root};
    assign rs1     = root_step(r_rs);
    assign rs2     = root_step(rs1);

    // Scale by the integer part of the exponent and apply the sign.
    assign shift_amt = 9'sd14 - 9'(r_pow_n);
    always_comb begin
        if (r_pow_n >= 7'sd15) begin
            fin_mag = SAT_MAX;
        end else if (shift_amt >= 9'sd31) begin
            fin_mag = 32'd0;
        end else begin
            fin_mag = 32'(r_root >> shift_amt[4:0]);
        end
        if (r_zero_in) begin
            fin_sig = 32'sd0;
        end else if (r_neg_in) begin
            fin_sig = $signed(32'(-fin_mag));
        end else begin
            fin_sig = $signed(fin_mag);
        end
    end

    // Per-estimate operand selection: accel, then rate, then value.
    always_comb begin
        unique case (q)
            2'd0: begin
                sig_a    = r_sig[0];
                sig_b    = r_sig[1];
                gain_sel = r_gain_third;
                upper    = 32'sd0;
                prev_sel = r_prev_accel;
                est_sel  = r_est_accel;
            end
            2'd1: begin
                sig_a    = r_sig[2];
                sig_b    = r_sig[3];
                gain_sel = r_gain_second;
                upper    = r_est_accel;
                prev_sel = r_prev_rate;
                est_sel  = r_est_rate;
            end
            2'd2: begin
                sig_a    = r_sig[4];
                sig_b    = r_sig[5];
                gain_sel = r_gain_first;
                upper    = r_est_rate;
                prev_sel = r_prev_value;
                est_sel  = r_est_value;
            end
            default: begin
                sig_a    = 32'sd0;
                sig_b    = 32'sd0;
                gain_sel = 32'd0;
                upper    = 32'sd0;
                prev_sel = 32'sd0;
                est_sel  = 32'sd0;
            end
        endcase
    end

    // Gain term, slope and trapezoid increment arithmetic.
    assign sum_sat   = sat34(34'(sig_a) + 34'(sig_b));
    assign work_mag  = r_work[31] ? 32'(-r_work) : 32'(r_work);
    assign slope_val = (q == 2'd0) ? r_term : sat34(34'(upper) + 34'(r_term));
    assign ss_mag    = r_slope_sum[32] ? 33'(-r_slope_sum) : 33'(r_slope_sum);
    assign iprod     = 57'(ss_mag) * 57'(r_step_time);
    assign inc_mag   = r_prod[56:25];
    assign inc       = r_prod_neg ? -$signed({2'b00, inc_mag}) : $signed({2'b00, inc_mag});
    assign est_next  = sat34(34'(est_sel) + inc);

    // Configuration and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_first  <= GAIN_RESET;
            r_gain_second <= GAIN_RESET;
            r_gain_third  <= GAIN_RESET;
            r_slow_exp    <= SLOW_EXP_RESET;
            r_fast_exp    <= FAST_EXP_RESET;
            r_step_time   <= STEP_RESET;
            r_est_accel   <= 32'sd0;
            r_est_rate    <= 32'sd0;
            r_est_value   <= 32'sd0;
            r_prev_accel  <= 32'sd0;
            r_prev_rate   <= 32'sd0;
            r_prev_value  <= 32'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GAIN_FIRST:    r_gain_first  <= i_cfg_data;
                REG_GAIN_SECOND:   r_gain_second <= i_cfg_data;
                REG_GAIN_THIRD:    r_gain_third  <= i_cfg_data;
                REG_SLOW_EXPONENT: r_slow_exp    <= i_cfg_data[15:0];
                REG_FAST_EXPONENT: r_fast_exp    <= i_cfg_data[15:0];
                REG_STEP_TIME:     r_step_time   <= i_cfg_data[23:0];
                REG_START_ESTIMATE: begin
                    r_est_value  <= $signed(i_cfg_data);
                    r_est_rate   <= 32'sd0;
                    r_est_accel  <= 32'sd0;
                    r_prev_value <= 32'sd0;
                    r_prev_rate  <= 32'sd0;
                    r_prev_accel <= 32'sd0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.op == OP_INTEG) begin
            unique case (q)
                2'd0: begin
                    r_est_accel  <= est_next;
                    r_prev_accel <= r_slope;
                end
                2'd1: begin
                    r_est_rate  <= est_next;
                    r_prev_rate <= r_slope;
                end
                2'd2: begin
                    r_est_value  <= est_next;
                    r_prev_value <= r_slope;
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers of the power unit and the integration steps.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_mag_z   <= sample_mag;
                r_lead    <= 5'd31;
                r_neg_in  <= i_sample[31];
                r_zero_in <= (i_sample == 32'sd0);
                r_frac    <= 24'd0;
            end
            OP_NORM: begin
                if ((r_mag_z & norm_mask) == 32'd0) begin
                    r_mag_z <= r_mag_z << norm_amt;
                    r_lead  <= r_lead - norm_amt;
                end
            end
            OP_SQUARE: begin
                r_frac  <= {r_frac[22:0], sq_top[32]};
                r_mag_z <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
            end
            OP_PLOAD: begin
                r_exp <= exp_sel;
            end
            OP_EXPMUL: begin
                r_pow_n <= y_full[44:38];
                r_pow_f <= y_full[37:14];
                r_root  <= ROOT_ONE;
            end
            OP_SLOAD: begin
                r_rs.rem     <= {2'b00, root_in, 30'd0};
                r_rs.res     <= 64'd0;
                r_rs.one_hot <= 64'd1 << 62;
            end
            OP_SITER: begin
                r_rs   <= rs2;
                r_root <= rs2.res[30:0];
            end
            OP_FIN: begin
                r_sig[i_cmd.idx[2:0]] <= fin_sig;
            end
            OP_SUM: begin
                r_work <= sum_sat;
            end
            OP_GMUL: begin
                r_prod     <= 64'(work_mag) * 64'(gain_sel);
                r_prod_neg <= r_work[31];
            end
            OP_GSHIFT: begin
                r_term <= sat_mag(r_prod_neg, r_prod[63:16]);
            end
            OP_SLOPE: begin
                r_slope     <= slope_val;
                r_slope_sum <= 33'(slope_val) + 33'(prev_sel);
            end
            OP_IMUL: begin
                r_prod     <= 64'(iprod);
                r_prod_neg <= r_slope_sum[32];
            end
            OP_OUTLOAD: begin
                r_out_value <= r_est_value;
                r_out_rate  <= r_est_rate;
                r_out_accel <= r_est_accel;
            end
            default: begin
            end
        endcase
    end

    assign o_estimate_value = r_out_value;
    assign o_estimate_rate  = r_out_rate;
    assign o_estimate_accel = r_out_accel;

endmodule

[rtl/fixed_time_differentiator_core.sv]
// Top level of the third-order fixed-time tracking differentiator.
// One tracking error sample (signed Q16.16) enters on the i_sample channel per transaction;
// each produces one transaction on o_result carrying the updated value, rate and
// acceleration estimates, all signed Q16.16 and saturated to 32 bits.
// The i_cfg channel writes the gains, the two exponents, the step time and the start
// estimate; it is always ready and must only be used while no sample is in flight.
// Writing the start estimate also clears the filter state.
// The sample channel takes no new sample until the result of the last one is loaded, and
// it becomes ready again in the same cycle in which that result is offered. Most of the
// work falls on the shared square-root unit: six powers, each of 24 nested roots made of
// one load and 16 iterations at two root bits per cycle, plus the steps that select the
// exponent, scale the log and store the power; on top come the 29 steps of log2, the 18
// integration steps and the load of the result register.
// The result register holds a finished result while the receiver stalls, and the next
// sample is accepted meanwhile; a later result waits until the register is taken.
// Synchronous active-low reset restores the configuration defaults and clears the filter and control state.
module fixed_time_differentiator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ftd_sample_if.sink          i_sample,
    ftd_result_if.source        o_result,
    ftd_cfg_if.sink             i_cfg
);
    import ftd_pkg::*;

    t_cmd cmd;

    assign i_cfg.ready = 1'b1;

    // Sequencer.
    ftd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    // Arithmetic and state.
    ftd_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_sample         (i_sample.error_sample),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .o_estimate_value (o_result.estimate_value),
        .o_estimate_rate  (o_result.estimate_rate),
        .o_estimate_accel (o_result.estimate_accel)
    );

endmodule

[rtl/ftd_checker.sv]
// Port-level checks of the differentiator, attached to the top level by bind.
module ftd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // A result transaction stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped before transaction completed");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Only one sample is worked on at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample channel ready right after a transaction");

    // A new result is only produced while the sample channel is busy.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while idle");

endmodule

bind fixed_time_differentiator_core ftd_checker u_ftd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready)
);
